// ----- rtl/v2n_pkg.sv -----
// Package for the 2D vector normaliser: single-precision constants and
// bit-exact float multiply and add functions. No dependencies.
package v2n_pkg;

  localparam logic [31:0] RsqrtMagic = 32'h5f3759df;
  localparam logic [31:0] OneHalf    = 32'h3fc00000;
  localparam logic [31:0] Half       = 32'h3f000000;
  localparam logic [31:0] CanonNan   = 32'h7fc00000;

  typedef struct packed {
    logic        valid;
    logic        two_steps;
  } ctl_t;

  function automatic logic is_nan(input logic [31:0] a);
    is_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  endfunction

  // Round a magnitude given as an exact significand with sticky, at a
  // biased exponent ex for bit position 47 of sig (value = sig * 2^(ex-127-47)).
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] ex,
                                             input logic [49:0] sig);
    logic [49:0] s;
    logic signed [11:0] e;
    logic [5:0] lz;
    logic sticky;
    logic [24:0] m;
    logic g;
    logic [25:0] mr;
    logic [7:0] ef;
    s = sig;
    e = ex;
    lz = 6'd0;
    for (int i = 49; i >= 0; i--) begin
      if (s[i] && lz == 6'd0) lz = 6'(50 - i);
    end
    if (s == 50'd0) begin
      round_pack = {sgn, 31'd0};
    end else begin
      // Normalise so the leading one sits at bit 49.
      e = e + 12'sd2 - 12'(signed'({6'd0, lz})) + 12'sd1;
      s = s << (lz - 6'd1);
      if (e < 12'sd1) begin
        sticky = 1'b0;
        for (int k = 0; k < 50; k++) begin
          if (12'sd1 - e > 12'(k)) sticky = sticky | s[k];
        end
        if (12'sd1 - e > 12'sd49) s = 50'd0;
        else s = s >> (12'sd1 - e);
        e = 12'sd0;
      end else begin
        sticky = 1'b0;
      end
      m = {1'b0, s[49:26]};
      g = s[25];
      sticky = sticky | (s[24:0] != 25'd0);
      mr = {1'b0, m} + {25'd0, (g && (sticky || m[0]))};
      if (mr[23] && e == 12'sd0) e = 12'sd1;
      if (mr[24]) begin
        mr = mr >> 1;
        e = e + 12'sd1;
      end
      if (e >= 12'sd255) round_pack = {sgn, 8'hff, 23'd0};
      else begin
        ef = e[7:0];
        round_pack = {sgn, ef, mr[22:0]};
      end
    end
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic sgn;
    logic [23:0] ma, mb;
    logic signed [11:0] ea, eb;
    logic [47:0] p;
    sgn = a[31] ^ b[31];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    ea = (a[30:23] == 8'd0) ? 12'sd1 : 12'(signed'({4'd0, a[30:23]}));
    eb = (b[30:23] == 8'd0) ? 12'sd1 : 12'(signed'({4'd0, b[30:23]}));
    if (is_nan(a) || is_nan(b)) fmul = CanonNan;
    else if (a[30:23] == 8'hff || b[30:23] == 8'hff) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) fmul = CanonNan;
      else fmul = {sgn, 8'hff, 23'd0};
    end else begin
      p = ma * mb;
      // p value = p * 2^(ea+eb-254-46); bit 46 weight exponent ea+eb-127.
      fmul = round_pack(sgn, ea + eb - 12'sd127 - 12'sd1, {p, 2'b00});
    end
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big, sml;
    logic [23:0] mb, ms;
    logic [7:0] eb, es, d;
    logic [49:0] xb, xs, r;
    logic st;
    logic sgn;
    if (is_nan(a) || is_nan(b)) fadd = CanonNan;
    else if (a[30:23] == 8'hff && b[30:23] == 8'hff) begin
      fadd = (a[31] == b[31]) ? a : CanonNan;
    end else if (a[30:23] == 8'hff) fadd = a;
    else if (b[30:23] == 8'hff) fadd = b;
    else begin
      if (a[30:0] >= b[30:0]) begin
        big = a; sml = b;
      end else begin
        big = b; sml = a;
      end
      mb = {big[30:23] != 8'd0, big[22:0]};
      ms = {sml[30:23] != 8'd0, sml[22:0]};
      eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d = eb - es;
      xb = {1'b0, mb, 25'd0};
      xs = {1'b0, ms, 25'd0};
      st = 1'b0;
      if (d > 8'd48) begin
        st = (xs != 50'd0);
        xs = 50'd0;
      end else begin
        for (int k = 0; k < 49; k++) begin
          if (8'(k) < d) st = st | xs[k];
        end
        xs = xs >> d;
      end
      xs[0] = xs[0] | st;
      if (big[31] == sml[31]) r = xb + xs;
      else r = xb - xs;
      if (r == 50'd0) begin
        sgn = a[31] & b[31];
        fadd = {sgn, 31'd0};
      end else begin
        // xb bit 48 has exponent eb; round_pack's bit 47 reference.
        fadd = round_pack(big[31], 12'(signed'({4'd0, eb})) + 12'sd1 - 12'sd2 + 12'sd0,
                          r);
      end
    end
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] a);
    canon = is_nan(a) ? CanonNan : a;
  endfunction

endpackage

// ----- rtl/v2n_newton.sv -----
// One Newton refinement step, or a pass-through of r_i when apply_i is low, cut over four register stages.
// Depends on v2n_pkg.
module v2n_newton (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  v2n_pkg::ctl_t ctl_i,
  input  logic        apply_i,
  input  logic [31:0] r_i,
  input  logic [31:0] h_i,
  input  logic [63:0] xy_i,
  output v2n_pkg::ctl_t ctl_o,
  output logic [31:0] r_o,
  output logic [31:0] h_o,
  output logic [63:0] xy_o
);
  v2n_pkg::ctl_t c_q [4];
  logic [3:0]  ap_q;
  logic [31:0] r_q [4];
  logic [31:0] h_q [4];
  logic [31:0] t_q [4];
  logic [63:0] xy_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) c_q[i] <= '0;
    end else if (en_i) begin
      c_q[0] <= ctl_i;
      for (int i = 1; i < 4; i++) c_q[i] <= c_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ap_q <= {ap_q[2:0], apply_i};
      r_q[0] <= r_i; h_q[0] <= h_i; xy_q[0] <= xy_i;
      t_q[0] <= v2n_pkg::fmul(h_i, r_i);
      for (int i = 1; i < 4; i++) begin
        r_q[i] <= r_q[i-1]; h_q[i] <= h_q[i-1]; xy_q[i] <= xy_q[i-1];
      end
      t_q[1] <= v2n_pkg::fmul(t_q[0], r_q[0]);
      t_q[2] <= v2n_pkg::fadd(v2n_pkg::OneHalf, {~t_q[1][31], t_q[1][30:0]});
      t_q[3] <= ap_q[2] ? v2n_pkg::fmul(r_q[2], t_q[2]) : r_q[2];
    end
  end

  assign ctl_o = c_q[3];
  assign r_o   = t_q[3];
  assign h_o   = h_q[3];
  assign xy_o  = xy_q[3];
endmodule

// ----- rtl/vector2_normalize_fast_rsqrt.sv -----
// Top level of the 2D vector normaliser with the fast inverse square root.
// Depends on v2n_pkg and v2n_newton.
//
// Input transactions carry x_bits_i and y_bits_i under in_valid_i and
// in_ready_o; results leave on norm_x_bits_o and norm_y_bits_o under
// out_valid_o and out_ready_i. Writing newton_steps_i while newton_steps_we_i
// is high sets one or two Newton steps; values 0 and 3 act as 1 and 2.
// The pipeline is fourteen stages deep: three for the squared length and
// the estimate, four for each of two Newton units, and three for the final
// scaling and output. A transaction is accepted every cycle while the
// output stage moves, so throughput is one per cycle.
// When one step is set, the second Newton unit passes the estimate through.
// When the receiver stalls, every stage holds as one; ready then follows
// whether the output stage is empty. Reset empties all stages and sets one
// Newton step.
module vector2_normalize_fast_rsqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] x_bits_i,
  input  logic [31:0] y_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] norm_x_bits_o,
  output logic [31:0] norm_y_bits_o,
  input  logic        newton_steps_we_i,
  input  logic [1:0]  newton_steps_i
);
  logic [1:0] steps_q;
  logic en;
  v2n_pkg::ctl_t c_q [3];
  v2n_pkg::ctl_t c1, c2, c3_q, c4_q, c5_q;
  logic [63:0] xy_q [3];
  logic [63:0] xy1, xy2;
  logic [31:0] xx_q, yy_q, n_q, h_q, r0_q;
  logic [31:0] r1, h1, r2, h2;
  logic [31:0] nx_q, ny_q, ox_q, oy_q;
  logic [63:0] xy3_q;
  logic [31:0] r3_q;

  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= 2'd1;
    end else if (newton_steps_we_i) begin
      steps_q <= newton_steps_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) c_q[i] <= '0;
      c3_q <= '0; c4_q <= '0; c5_q <= '0;
    end else if (en) begin
      c_q[0] <= '{valid: in_valid_i, two_steps: steps_q[1]};
      c_q[1] <= c_q[0];
      c_q[2] <= c_q[1];
      c3_q <= c2;
      c4_q <= c3_q;
      c5_q <= c4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xy_q[0] <= {x_bits_i, y_bits_i};
      xy_q[1] <= xy_q[0];
      xy_q[2] <= xy_q[1];
      xx_q <= v2n_pkg::fmul(x_bits_i, x_bits_i);
      yy_q <= v2n_pkg::fmul(y_bits_i, y_bits_i);
      n_q  <= v2n_pkg::fadd(xx_q, yy_q);
      h_q  <= v2n_pkg::fmul(n_q, v2n_pkg::Half);
      r0_q <= v2n_pkg::RsqrtMagic - {n_q[31], n_q[31:1]};
      xy3_q <= xy2;
      r3_q <= r2;
      nx_q <= v2n_pkg::fmul(xy3_q[63:32], r3_q);
      ny_q <= v2n_pkg::fmul(xy3_q[31:0], r3_q);
      ox_q <= v2n_pkg::canon(nx_q);
      oy_q <= v2n_pkg::canon(ny_q);
    end
  end

  v2n_newton u_step1 (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(c_q[2]), .apply_i(1'b1),
    .r_i(r0_q), .h_i(h_q), .xy_i(xy_q[2]),
    .ctl_o(c1), .r_o(r1), .h_o(h1), .xy_o(xy1)
  );

  v2n_newton u_step2 (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(c1), .apply_i(c1.two_steps),
    .r_i(r1), .h_i(h1), .xy_i(xy1),
    .ctl_o(c2), .r_o(r2), .h_o(h2), .xy_o(xy2)
  );

  assign out_valid_o   = c5_q.valid;
  assign norm_x_bits_o = ox_q;
  assign norm_y_bits_o = oy_q;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(norm_x_bits_o)))
    else $error("Output changed during a stall.");
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("Input accepted while the pipeline is stalled.");
  a_h_unused_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c2.valid && en) |=> c3_q.valid)
    else $error("Transaction lost between Newton stage and scaling.");
`endif
endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for vector2_normalize_fast_rsqrt: streams 2D float vectors under random
// stalls on both sides and checks each result against a bit-exact float predictor.
// Depends on v2n_pkg and the RTL of the normaliser.
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    logic [31:0] nx;
    logic [31:0] ny;
  } norm_pair_t;

  class norm_scoreboard;
    norm_pair_t  pending_q[$];
    logic [1:0]  steps_cfg = 2'd1;
    int          fails = 0;

    function bit f_is_nan(logic [31:0] a);
      return a[30:23] == 8'hff && a[22:0] != 23'd0;
    endfunction

    function logic [31:0] f_pack(bit s, logic [63:0] m, int e);
      int p, sh, bexp;
      logic [63:0] q, rem, halfv;
      bit up;
      if (m == 64'd0) return {s, 31'd0};
      p = 0;
      for (int i = 0; i < 64; i++) if (m[i]) p = i;
      bexp = p + e + 127;
      sh = (bexp >= 1) ? p - 23 : -149 - e;
      if (sh <= 0) q = m << (-sh);
      else if (sh >= 64) q = 64'd0;
      else begin
        q = m >> sh;
        rem = m & ((64'd1 << sh) - 64'd1);
        halfv = 64'd1 << (sh - 1);
        up = (rem > halfv) || (rem == halfv && q[0]);
        q = q + up;
      end
      if (bexp >= 1) begin
        if (q == (64'd1 << 24)) begin
          q = q >> 1;
          bexp++;
        end
        if (bexp >= 255) return {s, 8'hff, 23'd0};
        return {s, bexp[7:0], q[22:0]};
      end
      return {s, q[30:0]};
    endfunction

    function void f_split(logic [31:0] a, output logic [63:0] m, output int e);
      m = {40'd0, a[30:23] != 8'd0, a[22:0]};
      e = ((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) - 150;
    endfunction

    function logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma, mb;
      int ea, eb;
      bit s;
      s = a[31] ^ b[31];
      if (f_is_nan(a) || f_is_nan(b)) return v2n_pkg::CanonNan;
      if (a[30:23] == 8'hff || b[30:23] == 8'hff) begin
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return v2n_pkg::CanonNan;
        return {s, 8'hff, 23'd0};
      end
      f_split(a, ma, ea);
      f_split(b, mb, eb);
      return f_pack(s, ma * mb, ea + eb);
    endfunction

    function logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma, mb, m1, m2;
      logic [31:0] big, sml;
      int ea, eb, d, e;
      if (f_is_nan(a) || f_is_nan(b)) return v2n_pkg::CanonNan;
      if (a[30:23] == 8'hff && b[30:23] == 8'hff)
        return (a[31] == b[31]) ? a : v2n_pkg::CanonNan;
      if (a[30:23] == 8'hff) return a;
      if (b[30:23] == 8'hff) return b;
      if (a[30:23] >= b[30:23]) begin
        big = a; sml = b;
      end else begin
        big = b; sml = a;
      end
      f_split(big, ma, ea);
      f_split(sml, mb, eb);
      d = ea - eb;
      if (d <= 40) begin
        m1 = ma << d; m2 = mb; e = eb;
      end else begin
        m1 = ma << 40; m2 = {63'd0, mb != 64'd0}; e = ea - 40;
      end
      if (big[31] == sml[31]) return f_pack(big[31], m1 + m2, e);
      if (m1 == m2) return {a[31] & b[31], 31'd0};
      if (m1 > m2) return f_pack(big[31], m1 - m2, e);
      return f_pack(sml[31], m2 - m1, e);
    endfunction

    function norm_pair_t normalise(logic [31:0] x, logic [31:0] y);
      logic [31:0] n, h, r, t, halfw;
      int steps;
      norm_pair_t res;
      steps = (steps_cfg >= 2'd2) ? 2 : 1;
      n = f_add(f_mul(x, x), f_mul(y, y));
      h = f_mul(n, v2n_pkg::Half);
      halfw = (n >> 1) | (n & 32'h80000000);
      r = v2n_pkg::RsqrtMagic - halfw;
      for (int k = 0; k < steps; k++) begin
        t = f_mul(f_mul(h, r), r);
        t = f_add(v2n_pkg::OneHalf, {~t[31], t[30:0]});
        r = f_mul(r, t);
      end
      res.nx = f_mul(x, r);
      res.ny = f_mul(y, r);
      if (f_is_nan(res.nx)) res.nx = v2n_pkg::CanonNan;
      if (f_is_nan(res.ny)) res.ny = v2n_pkg::CanonNan;
      return res;
    endfunction

    function void note_vector(logic [31:0] x, logic [31:0] y);
      pending_q.push_back(normalise(x, y));
    endfunction

    function void check_norm(logic [31:0] nx, logic [31:0] ny);
      norm_pair_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction: norm_x_bits %h norm_y_bits %h", nx, ny);
        fails++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (nx !== exp_r.nx) begin
        $error("norm_x_bits: expected %h, actual %h", exp_r.nx, nx);
        fails++;
      end
      if (ny !== exp_r.ny) begin
        $error("norm_y_bits: expected %h, actual %h", exp_r.ny, ny);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] x_bits_i = 32'd0;
  logic [31:0] y_bits_i = 32'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] norm_x_bits_o;
  logic [31:0] norm_y_bits_o;
  logic        newton_steps_we_i = 1'b0;
  logic [1:0]  newton_steps_i = 2'd0;
  bit          no_gaps = 1'b0;

  norm_scoreboard sb = new();

  vector2_normalize_fast_rsqrt DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .x_bits_i, .y_bits_i,
    .out_valid_o, .out_ready_i, .norm_x_bits_o, .norm_y_bits_o,
    .newton_steps_we_i, .newton_steps_i
  );

  always #10 clk_i = ~clk_i;

  task automatic send_vector(logic [31:0] x, logic [31:0] y);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_bits_i <= x;
    y_bits_i <= y;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_vector(x, y);
  endtask

  task automatic set_steps(logic [1:0] v);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    newton_steps_we_i <= 1'b1;
    newton_steps_i <= v;
    @(posedge clk_i);
    newton_steps_we_i <= 1'b0;
    sb.steps_cfg = v;
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3, 4, 5: v[30:23] = 8'($urandom_range(100, 154));
      6: v[30:23] = 8'($urandom_range(0, 3));
      7: v[30:23] = 8'($urandom_range(230, 254));
      8: v[30:23] = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
      default: v[30:0] = ($urandom_range(0, 1) != 0) ? 31'd0 : {8'hff, 23'd0};
    endcase
    return v;
  endfunction

  always begin
    int w;
    w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (w > 0) begin
      out_ready_i <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    out_ready_i <= 1'b1;
    do @(posedge clk_i); while (!out_valid_o || !rst_ni);
    sb.check_norm(norm_x_bits_o, norm_y_bits_o);
  end

  initial begin
    logic [31:0] directed_q[$];
    logic [1:0] step_seq[4];
    step_seq = '{2'd1, 2'd2, 2'd0, 2'd3};
    directed_q = '{32'h00000000, 32'h80000000, 32'h3f800000, 32'hbf400000,
                   32'h7f7fffff, 32'hff7fffff, 32'h00000001, 32'h807fffff,
                   32'h7f800000, 32'hff800000, 32'h7fc00000, 32'hffffffff,
                   32'h00800000, 32'h5f000000, 32'h1f800000, 32'h40490fdb};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < directed_q.size(); i++)
      send_vector(directed_q[i], directed_q[(i * 5 + 3) % directed_q.size()]);
    send_vector(32'h00000000, 32'h00000000);
    send_vector(32'h80000000, 32'h80000000);
    send_vector(32'h7f800000, 32'h00000000);
    send_vector(32'h3f800000, 32'h00000000);
    for (int ph = 0; ph < 4; ph++) begin
      set_steps(step_seq[ph]);
      for (int i = 0; i < 110; i++) begin
        if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        send_vector(rand_float(), rand_float());
      end
      no_gaps = 1'b0;
    end
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule
